// ----- rtl/core/rfo_pkg.sv -----
// Shared types, codes and defaults for the rectangle rasterizer.
package rfo_pkg;

   // Default parameter values
   localparam int MAX_SIDE_DEF  = 256;
   localparam int FRAC_BITS_DEF = 8;

   // Field widths fixed by the interface
   localparam int COORD_W = 20;
   localparam int SIZE_W  = 9;
   localparam int CODE_W  = 8;
   localparam int POS_W   = 8;

   // Operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_CLEAR = 2'd0;
   localparam op_type OP_DRAW  = 2'd1;
   localparam op_type OP_READ  = 2'd2;
   localparam op_type OP_NONE  = 2'd3;

   // Configuration register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_CANVAS_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_CANVAS_HEIGHT = 2'd1;
   localparam csr_idx_type CSR_FILL_CODE     = 2'd2;

   // Configuration reset values
   localparam logic [SIZE_W-1:0] CANVAS_SIDE_RST = 9'd1;
   localparam logic [CODE_W-1:0] FILL_CODE_RST   = 8'd32;

   // Request transaction
   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  rect_left;
      logic signed [COORD_W-1:0]  rect_top;
      logic signed [COORD_W-1:0]  rect_wide;
      logic signed [COORD_W-1:0]  rect_tall;
      logic                       solid;
      logic [CODE_W-1:0]          ink;
      logic [POS_W-1:0]           read_col;
      logic [POS_W-1:0]           read_row;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [CODE_W-1:0] pixel;
      logic              status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture request and canvas size
      logic rd_en;     // read one canvas pixel
      logic step;      // visit one pixel of the sweep
      logic rsp_load;  // capture the response payload
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
      logic   reject;
      logic   last;
   } sts_type;

endpackage

// ----- rtl/core/rfo_ctrl.sv -----
// Controller state machine for the rectangle rasterizer.
module rfo_ctrl
   import rfo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Sequence one transaction at a time
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_CLEAR: state_in = ST_SWEEP;
               OP_DRAW:  state_in = sts.reject ? ST_DONE : ST_SWEEP;
               OP_READ: begin
                  cmd.rd_en = 1'b1;
                  state_in  = ST_DONE;
               end
               default:  state_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/rfo_dpath.sv -----
// Datapath of the rectangle rasterizer: settings, bounds, sweep counters, canvas memory.
module rfo_dpath
   import rfo_pkg::*;
#(
   parameter int MAX_SIDE  = MAX_SIDE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  csr_idx_type       csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  req_type           req_payload,
   output rsp_type           rsp_payload,
   input  cmd_type           cmd,
   output sts_type           sts
);

   localparam int CW   = $clog2(MAX_SIDE);
   localparam int CMPW = CW + SIZE_W;
   localparam int DW   = CW + FRAC_BITS + 24;
   localparam int AW   = 2 * CW;
   localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   // Configuration registers
   logic [SIZE_W-1:0] cfg_width_ff, cfg_height_ff;
   logic [CODE_W-1:0] cfg_fill_ff;

   // Captured transaction
   op_type             op_ff;
   logic               reject_ff, solid_ff, in_range_ff;
   logic [CODE_W-1:0]  ink_ff;
   logic [CW-1:0]      rcol_ff, rrow_ff;
   logic [CW-1:0]      col_last_ff, row_last_ff;
   logic signed [DW-1:0] xl_ff, xe_ff, xf_ff, xr_ff;
   logic signed [DW-1:0] yt_ff, ye_ff, yf_ff, yb_ff;

   // Sweep position and memory read data
   logic [CW-1:0]     col_ff, row_ff;
   logic [CODE_W-1:0] rd_data_ff;
   rsp_type           rsp_ff;

   logic [CMPW-1:0]      w_use, h_use, rcol_w, rrow_w;
   logic signed [DW-1:0] x_in, y_in, w_in, h_in, xr_in, yb_in;
   logic signed [DW-1:0] px, py;
   logic                 in_rect, edge_hit, mem_we, col_end;
   logic [CODE_W-1:0]    wr_data;
   logic [CODE_W-1:0]    canvas_mem [2**AW];

   // Clamp the canvas size to the range in use
   always_comb begin
      w_use = CMPW'(cfg_width_ff);
      h_use = CMPW'(cfg_height_ff);
      if (w_use == '0) begin
         w_use = CMPW'(1);
      end else if (w_use > CMPW'(MAX_SIDE)) begin
         w_use = CMPW'(MAX_SIDE);
      end
      if (h_use == '0) begin
         h_use = CMPW'(1);
      end else if (h_use > CMPW'(MAX_SIDE)) begin
         h_use = CMPW'(MAX_SIDE);
      end
   end

   // Rectangle bounds from the request
   assign x_in   = DW'(req_payload.rect_left);
   assign y_in   = DW'(req_payload.rect_top);
   assign w_in   = DW'(req_payload.rect_wide);
   assign h_in   = DW'(req_payload.rect_tall);
   assign xr_in  = x_in + w_in;
   assign yb_in  = y_in + h_in;
   assign rcol_w = CMPW'(req_payload.read_col);
   assign rrow_w = CMPW'(req_payload.read_row);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CANVAS_SIDE_RST;
         cfg_height_ff <= CANVAS_SIDE_RST;
         cfg_fill_ff   <= FILL_CODE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  cfg_width_ff  <= csr_wdata;
            CSR_CANVAS_HEIGHT: cfg_height_ff <= csr_wdata;
            CSR_FILL_CODE:     cfg_fill_ff   <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the transaction and its precomputed bounds
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_payload.op;
         reject_ff   <= (w_in < ONE) || (h_in < ONE);
         solid_ff    <= req_payload.solid;
         ink_ff      <= req_payload.ink;
         in_range_ff <= (rcol_w < w_use) && (rrow_w < h_use);
         rcol_ff     <= rcol_w[CW-1:0];
         rrow_ff     <= rrow_w[CW-1:0];
         col_last_ff <= CW'(w_use - CMPW'(1));
         row_last_ff <= CW'(h_use - CMPW'(1));
         xl_ff       <= x_in;
         xe_ff       <= x_in + ONE;
         xf_ff       <= xr_in - ONE;
         xr_ff       <= xr_in;
         yt_ff       <= y_in;
         ye_ff       <= y_in + ONE;
         yf_ff       <= yb_in - ONE;
         yb_ff       <= yb_in;
      end
   end

   // Classify the current pixel against the rectangle
   assign px       = DW'(col_ff) << FRAC_BITS;
   assign py       = DW'(row_ff) << FRAC_BITS;
   assign in_rect  = (px >= xl_ff) && (py >= yt_ff) && (px <= xr_ff) && (py <= yb_ff);
   assign edge_hit = (px < xe_ff) || (py < ye_ff) || (px > xf_ff) || (py > yf_ff);
   assign col_end  = (col_ff == col_last_ff);

   always_comb begin
      if (op_ff == OP_CLEAR) begin
         mem_we  = cmd.step;
         wr_data = cfg_fill_ff;
      end else begin
         mem_we  = cmd.step && in_rect && (edge_hit || solid_ff);
         wr_data = ink_ff;
      end
   end

   // Advance the sweep row by row
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.step) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_ff + CW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // Canvas memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[{row_ff, col_ff}] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= canvas_mem[{rrow_ff, rcol_ff}];
      end
   end

   // Build the response
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.pixel  <= ((op_ff == OP_READ) && in_range_ff) ? rd_data_ff : '0;
         rsp_ff.status <= (op_ff == OP_DRAW) && reject_ff;
      end
   end

   assign rsp_payload = rsp_ff;
   assign sts.op      = op_ff;
   assign sts.reject  = reject_ff;
   assign sts.last    = col_end && (row_ff == row_last_ff);

endmodule

// ----- rtl/core/rectangle_fill_outline_rasterizer.sv -----
// Top level of the character-canvas rectangle rasterizer.
//
// Requests arrive on req_valid/req_stall/req_payload; each one yields exactly
// one response on rsp_valid/rsp_stall/rsp_payload. Canvas size and background
// code are written through csr_wr_en/csr_index/csr_wdata; the user must write
// them only while the block idles, as the block itself does not enforce it.
// One transaction is in work at a time. From acceptance, a read pixel,
// rejected rectangle or unused op passes the decode and done states before
// its response is valid; a clear or draw sweeps width * height canvas pixels
// in the sweep state between them, one canvas pixel per cycle, set by the
// single write port of the canvas memory.
// The response sits in an output register, so the next request is accepted
// while a finished response still waits; a later response waits in the
// controller until that register drains. A stalled response holds its value.
// Reset clears the controller and the configuration registers (width 1,
// height 1, background code 32). Canvas contents are undefined until a clear
// or draw writes them; no clearing pass is run.
module rectangle_fill_outline_rasterizer
   import rfo_pkg::*;
#(
   parameter int MAX_SIDE  = MAX_SIDE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  csr_idx_type       csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   // Sequence each transaction
   rfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold settings, bounds and the canvas
   rfo_dpath #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ----- rtl/core/rfo_checker.sv -----
// Port-level checks for the rectangle rasterizer, bound to the top level.
module rfo_checker
   import rfo_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_type           rsp_payload
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // Reset leaves no response pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only one transaction in work: stall right after acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted back to back");

   // A rejected rectangle carries no pixel
   a_reject_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status |-> rsp_payload.pixel == '0)
      else $error("reject status with nonzero pixel");

endmodule

bind rectangle_fill_outline_rasterizer rfo_checker u_rfo_checker (.*);
